// ----- design/srtm_pkg.sv -----
// ----------------------------------------------------------------------------
// srtm_pkg
// Shared types and constants for the segment range table: table size,
// operation and status codes, and the request, response and match structs.
// ----------------------------------------------------------------------------
package srtm_pkg;

	// Number of table slots.
	localparam int Segments = 8;
	localparam int SlotW    = (Segments > 1) ? $clog2(Segments) : 1;
	localparam int CntW     = $clog2(Segments + 1);

	typedef logic [63:0]      addr_t;
	typedef logic [SlotW-1:0] slot_idx_t;
	typedef logic [CntW-1:0]  cnt_t;

	// Operation codes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_MAP    = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_STRADDLE = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic       op;
		addr_t      addr;
		logic [6:0] access_size;
		addr_t      range_end;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [2:0] slot;
		addr_t      offset;
		logic [3:0] count;
	} rsp_t;

	// First matching slot for one search key.
	typedef struct packed {
		logic      hit;
		slot_idx_t slot;
	} match_t;

endpackage

// ----- design/srtm_match.sv -----
// ----------------------------------------------------------------------------
// srtm_match
// Compares one key against every valid slot in parallel and returns the
// lowest slot whose range [lo, hi) holds the key.
// ----------------------------------------------------------------------------
module srtm_match (
	input  srtm_pkg::addr_t                   key,
	input  srtm_pkg::addr_t                   seg_lo [srtm_pkg::Segments],
	input  srtm_pkg::addr_t                   seg_hi [srtm_pkg::Segments],
	input  logic [srtm_pkg::Segments-1:0]     entry_vld,
	output srtm_pkg::match_t                  match
);

	logic [srtm_pkg::Segments-1:0] in_range;

	always_comb begin
		for (int i = 0; i < srtm_pkg::Segments; i++) begin
			in_range[i] = entry_vld[i] && (seg_lo[i] <= key) && (key < seg_hi[i]);
		end
	end

	// Priority pick: walk down so that the lowest slot wins.
	always_comb begin
		match = '0;
		for (int i = srtm_pkg::Segments - 1; i >= 0; i--) begin
			if (in_range[i]) begin
				match.hit  = 1'b1;
				match.slot = srtm_pkg::slot_idx_t'(i);
			end
		end
	end

endmodule

// ----- design/segment_range_translate_merge.sv -----
// ----------------------------------------------------------------------------
// segment_range_translate_merge
// Segment range table with address translation and range coalescing.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload           Direction
//   -------   -------------------   ---------------   ---------
//   request   req_valid/req_stall   req  (req_t)      in
//   response  rsp_valid/rsp_stall   rsp  (rsp_t)      out
//
// Every request transaction yields exactly one response transaction, in order.
// A transaction passes through the input register and then the response
// register, and one transaction can be taken every cycle while the response
// is not stalled; the table update is made in that single pass.
// Reset clears the valid flags and the segment count; slot contents are not
// reset and are only ever read below the count.
// A stalled response holds the input register, and req_stall then rises.
//
// The input stage precomputes the search keys: for a lookup the address and
// the last byte of the access, for a map request the two neighbor probes
// (start - 1 and end + 1). The second stage matches both keys against all
// slots in parallel, forms the response, and writes the table: append,
// grow one neighbor, or merge two neighbors and refill the second slot from
// the last one. If the first merged slot is itself the last slot, the merged
// range is what lands in the refilled slot.
// ----------------------------------------------------------------------------
module segment_range_translate_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  srtm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output srtm_pkg::rsp_t  rsp
);

	localparam int Segments = srtm_pkg::Segments;
	localparam int SlotW    = srtm_pkg::SlotW;

	// Stage-one payload: the request plus keys worked out on entry.
	typedef struct packed {
		logic            op;
		srtm_pkg::addr_t addr;
		srtm_pkg::addr_t range_end;
		srtm_pkg::addr_t key_a;
		srtm_pkg::addr_t key_b;
		logic            wrap;
		logic            empty;
	} stage_t;

	// ---------------------------------------------------------------------
	// Input stage
	// ---------------------------------------------------------------------
	logic       s1_valid_q;
	stage_t     stage_s1;
	stage_t     stage_d;
	logic       adv;
	logic [6:0] size_eff;
	logic [64:0] last_sum;

	// The pipeline advances when the input register holds a transaction and
	// the response register is free or being emptied this cycle.
	assign adv       = s1_valid_q && (!rsp_valid || !rsp_stall);
	assign req_stall = s1_valid_q && rsp_valid && rsp_stall;

	always_comb begin
		// An access size of zero counts as one byte.
		size_eff = (req.access_size == 7'd0) ? 7'd1 : req.access_size;
		last_sum = {1'b0, req.addr} + {58'd0, size_eff - 7'd1};

		stage_d.op        = req.op;
		stage_d.addr      = req.addr;
		stage_d.range_end = req.range_end;
		stage_d.wrap      = last_sum[64];
		stage_d.empty     = (req.range_end <= req.addr);
		if (req.op == srtm_pkg::OP_MAP) begin
			stage_d.key_a = req.addr - 64'd1;
			stage_d.key_b = req.range_end + 64'd1;
		end else begin
			stage_d.key_a = req.addr;
			stage_d.key_b = last_sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!req_stall) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			stage_s1 <= stage_d;
		end
	end

	// ---------------------------------------------------------------------
	// Segment table
	// ---------------------------------------------------------------------
	srtm_pkg::addr_t seg_lo_q [Segments];
	srtm_pkg::addr_t seg_hi_q [Segments];
	srtm_pkg::addr_t seg_lo_nx [Segments];
	srtm_pkg::addr_t seg_hi_nx [Segments];
	srtm_pkg::cnt_t  count_q;
	srtm_pkg::cnt_t  count_nx;
	logic [Segments-1:0] entry_vld;

	always_comb begin
		for (int i = 0; i < Segments; i++) begin
			entry_vld[i] = (srtm_pkg::cnt_t'(i) < count_q);
		end
	end

	// ---------------------------------------------------------------------
	// Parallel match on both keys
	// ---------------------------------------------------------------------
	srtm_pkg::match_t match_a;
	srtm_pkg::match_t match_b;

	srtm_match u_match_a (
		.key       (stage_s1.key_a),
		.seg_lo    (seg_lo_q),
		.seg_hi    (seg_hi_q),
		.entry_vld (entry_vld),
		.match     (match_a)
	);

	srtm_match u_match_b (
		.key       (stage_s1.key_b),
		.seg_lo    (seg_lo_q),
		.seg_hi    (seg_hi_q),
		.entry_vld (entry_vld),
		.match     (match_b)
	);

	// ---------------------------------------------------------------------
	// Response and table update
	// ---------------------------------------------------------------------
	srtm_pkg::addr_t   offs [Segments];
	srtm_pkg::addr_t   merge_lo;
	srtm_pkg::addr_t   merge_hi;
	srtm_pkg::addr_t   grow_lo;
	srtm_pkg::addr_t   grow_hi;
	srtm_pkg::slot_idx_t last_idx;
	srtm_pkg::slot_idx_t grow_idx;
	srtm_pkg::slot_idx_t app_idx;
	srtm_pkg::rsp_t    rsp_d;

	// Offsets are formed for every slot alongside the compares, then picked.
	always_comb begin
		for (int i = 0; i < Segments; i++) begin
			offs[i] = stage_s1.addr - seg_lo_q[i];
		end
	end

	always_comb begin
		last_idx = SlotW'(count_q - srtm_pkg::cnt_t'(1));
		app_idx  = SlotW'(count_q);
		grow_idx = match_a.hit ? match_a.slot : match_b.slot;

		// Merged range of the two neighbors; it never shrinks either one.
		merge_lo = (seg_lo_q[match_a.slot] < seg_lo_q[match_b.slot]) ?
			seg_lo_q[match_a.slot] : seg_lo_q[match_b.slot];
		merge_hi = (seg_hi_q[match_a.slot] > seg_hi_q[match_b.slot]) ?
			seg_hi_q[match_a.slot] : seg_hi_q[match_b.slot];

		// One neighbor grows to cover the new range.
		grow_lo = (seg_lo_q[grow_idx] < stage_s1.addr) ?
			seg_lo_q[grow_idx] : stage_s1.addr;
		grow_hi = (seg_hi_q[grow_idx] > stage_s1.range_end) ?
			seg_hi_q[grow_idx] : stage_s1.range_end;
	end

	always_comb begin
		rsp_d    = '0;
		count_nx = count_q;
		for (int i = 0; i < Segments; i++) begin
			seg_lo_nx[i] = seg_lo_q[i];
			seg_hi_nx[i] = seg_hi_q[i];
		end

		if (stage_s1.op == srtm_pkg::OP_LOOKUP) begin
			if (!match_a.hit) begin
				rsp_d.status = srtm_pkg::ST_MISS;
			end else begin
				rsp_d.hit    = 1'b1;
				rsp_d.slot   = 3'(match_a.slot);
				rsp_d.offset = offs[match_a.slot];
				// The last byte must sit in the same first-matching slot.
				if (stage_s1.wrap || !match_b.hit || (match_b.slot != match_a.slot)) begin
					rsp_d.status = srtm_pkg::ST_STRADDLE;
				end
			end
		end else if (!stage_s1.empty) begin
			if (!match_a.hit && !match_b.hit) begin
				if (count_q >= srtm_pkg::cnt_t'(Segments)) begin
					rsp_d.status = srtm_pkg::ST_FULL;
				end else begin
					seg_lo_nx[app_idx] = stage_s1.addr;
					seg_hi_nx[app_idx] = stage_s1.range_end;
					count_nx = count_q + srtm_pkg::cnt_t'(1);
				end
			end else if (match_a.hit && match_b.hit) begin
				if (match_a.slot != match_b.slot) begin
					seg_lo_nx[match_a.slot] = merge_lo;
					seg_hi_nx[match_a.slot] = merge_hi;
					if (last_idx == match_a.slot) begin
						seg_lo_nx[match_b.slot] = merge_lo;
						seg_hi_nx[match_b.slot] = merge_hi;
					end else begin
						seg_lo_nx[match_b.slot] = seg_lo_q[last_idx];
						seg_hi_nx[match_b.slot] = seg_hi_q[last_idx];
					end
					count_nx = count_q - srtm_pkg::cnt_t'(1);
				end
			end else begin
				seg_lo_nx[grow_idx] = grow_lo;
				seg_hi_nx[grow_idx] = grow_hi;
			end
		end

		rsp_d.count = 4'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv) begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_lo_q <= seg_lo_nx;
			seg_hi_q <= seg_hi_nx;
		end
	end

	// ---------------------------------------------------------------------
	// Response register
	// ---------------------------------------------------------------------
	logic           rsp_valid_q;
	srtm_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------

	// The segment count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= srtm_pkg::cnt_t'(Segments))
		else $error("segment count above table size");

	// The count only moves when a map transaction leaves the input stage.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && stage_s1.op == srtm_pkg::OP_MAP) |=> $stable(count_q))
		else $error("segment count changed without a map transaction");

	// A full-table response is only given when the table is full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == srtm_pkg::ST_FULL |-> rsp.count == 4'(Segments))
		else $error("table full reported below capacity");

	// A hit carries either an ok or a straddle status.
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |->
			(rsp.status == srtm_pkg::ST_OK || rsp.status == srtm_pkg::ST_STRADDLE))
		else $error("hit response with miss or full status");

endmodule
